@@ hw/rtl/bfa_pkg.sv @@
package bfa_pkg;

  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned PAGE_W      = 12;
  localparam logic [12:0] NUM_FRAMES  = 13'd4096;

  localparam logic [1:0] ACT_INIT    = 2'd0;
  localparam logic [1:0] ACT_RESERVE = 2'd1;
  localparam logic [1:0] ACT_ALLOC   = 2'd2;
  localparam logic [1:0] ACT_FREE    = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OOM      = 3'd1;
  localparam logic [2:0] ST_UNALIGN  = 3'd2;
  localparam logic [2:0] ST_BOUNDS   = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;

  localparam logic [1:0] CFG_RAM_BASE  = 2'd0;
  localparam logic [1:0] CFG_RAM_START = 2'd1;
  localparam logic [1:0] CFG_RAM_SIZE  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] addr;
    logic [63:0] end_addr;
    logic [12:0] count;
  } in_item_t;

  typedef struct packed {
    logic [63:0] frame_addr;
    logic [2:0]  status;
    logic [12:0] double_free_pages;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT_FILL,
    S_MR_CLAMP,
    S_MR_INDEX,
    S_MR_MARK,
    S_AL_MOD,
    S_AL_RD,
    S_AL_CHK,
    S_AL_MARK,
    S_FR_SETUP,
    S_FR_RD,
    S_FR_CHK,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/bfa_map_ram.sv @@
module bfa_map_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [bfa_pkg::PAGE_W-1:0] waddr,
  input  logic                      wdata,
  input  logic [bfa_pkg::PAGE_W-1:0] raddr,
  output logic                      rdata
);
  import bfa_pkg::*;

  logic mem [2**PAGE_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/bitmap_frame_allocator.sv @@
// channel | dir | handshake           | payload
// in      | in  | in_valid / in_stall  | in_item (action, addr, end_addr, count)
// out     | out | out_valid / out_stall| out_item (frame_addr, status, double_free_pages)
// cfg     | in  | cfg_we               | cfg_index, cfg_wdata
// one item at a time; at most one page of the used map is touched per step of the sequencer
// reserve: clamp, index, a mark per page, then done; init: a fill of every map page runs first
// alloc: modulo steps on the search pointer, a read and a check per scanned page, a mark per page, done
// free: setup, a read and a check per page, then done; after reset a clear of every page holds in_stall
// reset is synchronous active low; out_stall holds the output register and the done state
module bitmap_frame_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bfa_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output bfa_pkg::out_item_t out_item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_wdata
);
  import bfa_pkg::*;

  // configuration
  logic [63:0] ram_base_r, ram_start_r;
  logic [24:0] ram_size_r;

  // sequencer state
  state_t      state_r, state_nxt;
  logic [1:0]  act_r, act_nxt;
  logic [63:0] addr_r, addr_nxt;
  logic [63:0] end_r, end_nxt;
  logic [12:0] cnt_r, cnt_nxt;
  logic [12:0] pg_r, pg_nxt;       // current page index
  logic [12:0] eip_r, eip_nxt;     // end page, exclusive
  logic [12:0] scan_r, scan_nxt;
  logic [12:0] run_r, run_nxt;
  logic [11:0] first_r, first_nxt;
  logic [11:0] sp_r, sp_nxt;       // search pointer
  logic [12:0] rem_r, rem_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [12:0] dbl_r, dbl_nxt;
  logic [63:0] frame_r, frame_nxt;
  logic [2:0]  status_r, status_nxt;

  logic      out_valid_r;
  out_item_t out_item_r;

  // map memory
  logic              ram_we, ram_wdata, ram_rdata;
  logic [PAGE_W-1:0] ram_raddr;

  logic in_fire, out_free;
  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // derived sizes
  logic [64:0] end_sum;
  logic [63:0] ram_end;
  logic [12:0] n_w;
  assign end_sum = {1'b0, ram_start_r} + {40'd0, ram_size_r};
  assign ram_end = end_sum[64] ? '1 : end_sum[63:0];
  assign n_w     = (ram_size_r[24:12] > NUM_FRAMES) ? NUM_FRAMES : ram_size_r[24:12];

  // range to page indexes
  logic [63:0] lo_off, hi_off;
  logic [52:0] ei_full;
  logic [12:0] ei_cl;
  logic        lo_below, mr_any;
  assign lo_off   = addr_r - ram_base_r;
  assign hi_off   = end_r - ram_base_r;
  assign lo_below = addr_r < ram_base_r;
  assign ei_full  = {1'b0, hi_off[63:12]} + {52'd0, (hi_off[11:0] != 12'd0)};
  always_comb begin
    if (end_r <= ram_base_r) begin
      ei_cl = 13'd0;
    end else if (ei_full > {40'd0, n_w}) begin
      ei_cl = n_w;
    end else begin
      ei_cl = ei_full[12:0];
    end
  end
  assign mr_any = lo_below ? (ei_cl != 13'd0) : (lo_off[63:12] < {39'd0, ei_cl});

  // modulo step of the search pointer
  logic [12:0] rem_sh;
  assign rem_sh = {rem_r[11:0], sp_r[bit_r]};

  // run tracking
  logic [12:0] run_base, run_inc, idx_inc;
  logic        found;
  assign run_base = (pg_r == 13'd0) ? 13'd0 : run_r;
  assign run_inc  = run_base + 13'd1;
  assign found    = !ram_rdata && (run_inc == cnt_r);
  assign idx_inc  = ((pg_r + 13'd1) == n_w) ? 13'd0 : pg_r + 13'd1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:     if (pg_r[11:0] == '1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_item.action)
            ACT_INIT:    state_nxt = S_INIT_FILL;
            ACT_RESERVE: state_nxt = S_MR_CLAMP;
            ACT_ALLOC:   state_nxt = (in_item.count == 13'd0 || n_w == 13'd0) ? S_DONE : S_AL_MOD;
            default:     state_nxt = S_FR_SETUP;
          endcase
        end
      end
      S_INIT_FILL: if (pg_r[11:0] == '1) state_nxt = S_MR_CLAMP;
      S_MR_CLAMP:  state_nxt = S_MR_INDEX;
      S_MR_INDEX:  state_nxt = mr_any ? S_MR_MARK : S_DONE;
      S_MR_MARK:   if (pg_r + 13'd1 >= eip_r) state_nxt = S_DONE;
      S_AL_MOD:    if (bit_r == 4'd0) state_nxt = S_AL_RD;
      S_AL_RD:     state_nxt = S_AL_CHK;
      S_AL_CHK: begin
        if (found) state_nxt = S_AL_MARK;
        else if (scan_r + 13'd1 >= n_w) state_nxt = S_DONE;
        else state_nxt = S_AL_RD;
      end
      S_AL_MARK:   if (pg_r + 13'd1 >= eip_r) state_nxt = S_DONE;
      S_FR_SETUP: begin
        if (addr_r[FRAME_SHIFT-1:0] != '0 || addr_r < ram_start_r || addr_r >= ram_end
            || lo_below || cnt_r == 13'd0 || lo_off[63:24] != '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FR_RD;
        end
      end
      S_FR_RD:     state_nxt = S_FR_CHK;
      S_FR_CHK: begin
        if (scan_r + 13'd1 == cnt_r || pg_r[11:0] == '1) state_nxt = S_DONE;
        else state_nxt = S_FR_RD;
      end
      S_DONE:      if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    act_nxt    = act_r;
    addr_nxt   = addr_r;
    end_nxt    = end_r;
    cnt_nxt    = cnt_r;
    pg_nxt     = pg_r;
    eip_nxt    = eip_r;
    scan_nxt   = scan_r;
    run_nxt    = run_r;
    first_nxt  = first_r;
    sp_nxt     = sp_r;
    rem_nxt    = rem_r;
    bit_nxt    = bit_r;
    dbl_nxt    = dbl_r;
    frame_nxt  = frame_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_wdata  = 1'b0;
    ram_raddr  = pg_r[11:0];
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        pg_nxt = pg_r + 13'd1;
      end
      S_IDLE: begin
        act_nxt    = in_item.action;
        addr_nxt   = in_item.addr;
        end_nxt    = in_item.end_addr;
        cnt_nxt    = in_item.count;
        pg_nxt     = 13'd0;
        scan_nxt   = 13'd0;
        run_nxt    = 13'd0;
        rem_nxt    = 13'd0;
        bit_nxt    = 4'd11;
        dbl_nxt    = 13'd0;
        frame_nxt  = 64'd0;
        status_nxt = ST_OK;
        if (in_item.action == ACT_ALLOC) begin
          if (in_item.count == 13'd0) status_nxt = ST_ZERO;
          else if (n_w == 13'd0) status_nxt = ST_OOM;
        end
      end
      S_INIT_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = ({1'b0, pg_r[11:0]} >= n_w);
        pg_nxt    = pg_r + 13'd1;
      end
      S_MR_CLAMP: begin
        if (addr_r < ram_start_r) addr_nxt = ram_start_r;
        if (end_r > ram_end) end_nxt = ram_end;
      end
      S_MR_INDEX: begin
        pg_nxt  = lo_below ? 13'd0 : lo_off[24:12];
        eip_nxt = ei_cl;
      end
      S_MR_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b1;
        pg_nxt    = pg_r + 13'd1;
      end
      S_AL_MOD: begin
        rem_nxt = (rem_sh >= n_w) ? rem_sh - n_w : rem_sh;
        bit_nxt = bit_r - 4'd1;
        if (bit_r == 4'd0) pg_nxt = (rem_sh >= n_w) ? rem_sh - n_w : rem_sh;
      end
      S_AL_RD: begin
        ram_raddr = pg_r[11:0];
      end
      S_AL_CHK: begin
        scan_nxt = scan_r + 13'd1;
        pg_nxt   = idx_inc;
        if (!ram_rdata) begin
          run_nxt = run_inc;
          if (run_base == 13'd0) first_nxt = pg_r[11:0];
        end else begin
          run_nxt = 13'd0;
        end
        if (found) begin
          // restart at the first page of the run to mark it
          pg_nxt  = (run_base == 13'd0) ? pg_r : {1'b0, first_r};
          eip_nxt = ((run_base == 13'd0) ? pg_r : {1'b0, first_r}) + cnt_r;
        end else if (scan_r + 13'd1 >= n_w) begin
          status_nxt = ST_OOM;
        end
      end
      S_AL_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b1;
        pg_nxt    = pg_r + 13'd1;
        if (pg_r + 13'd1 >= eip_r) begin
          sp_nxt    = (eip_r >= n_w) ? 12'(eip_r - n_w) : eip_r[11:0];
          frame_nxt = ram_base_r + {40'd0, first_r, 12'd0};
        end
      end
      S_FR_SETUP: begin
        if (addr_r[FRAME_SHIFT-1:0] != '0) status_nxt = ST_UNALIGN;
        else if (addr_r < ram_start_r || addr_r >= ram_end) status_nxt = ST_BOUNDS;
        pg_nxt = {1'b0, lo_off[23:12]};
      end
      S_FR_RD: begin
        ram_raddr = pg_r[11:0];
      end
      S_FR_CHK: begin
        if (!ram_rdata) begin
          dbl_nxt = dbl_r + 13'd1;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = 1'b0;
        end
        scan_nxt = scan_r + 13'd1;
        pg_nxt   = pg_r + 13'd1;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  bfa_map_ram u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pg_r[11:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pg_r        <= 13'd0;
      sp_r        <= 12'd0;
      out_valid_r <= 1'b0;
      ram_base_r  <= 64'd2147483648;
      ram_start_r <= 64'd2147483648;
      ram_size_r  <= 25'd16777216;
    end else begin
      state_r <= state_nxt;
      pg_r    <= pg_nxt;
      sp_r    <= sp_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_RAM_BASE:  ram_base_r  <= cfg_wdata;
          CFG_RAM_START: ram_start_r <= cfg_wdata;
          CFG_RAM_SIZE:  ram_size_r  <= cfg_wdata[24:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    addr_r   <= addr_nxt;
    end_r    <= end_nxt;
    cnt_r    <= cnt_nxt;
    eip_r    <= eip_nxt;
    scan_r   <= scan_nxt;
    run_r    <= run_nxt;
    first_r  <= first_nxt;
    rem_r    <= rem_nxt;
    bit_r    <= bit_nxt;
    dbl_r    <= dbl_nxt;
    frame_r  <= frame_nxt;
    status_r <= status_nxt;
    if (state_r == S_DONE && out_free) begin
      out_item_r.frame_addr        <= frame_r;
      out_item_r.status            <= status_r;
      out_item_r.double_free_pages <= (act_r == ACT_FREE) ? dbl_r : 13'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("accepted item left sequencer idle");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside done");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !ram_we)
    else $error("map written while idle");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_AL_CHK |-> scan_r < n_w)
    else $error("scan past page count");

endmodule
